>>> rtl/ofru_pkg.sv
package ofru_pkg;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int CFG_W          = 5;
    localparam int CNT_OUT_W      = 5;
    localparam int KIND_W         = 3;

    typedef enum logic [KIND_W-1:0] {
        K_ENQ       = 3'd0,
        K_DEQ       = 3'd1,
        K_PEEK_HEAD = 3'd2,
        K_PEEK_TAIL = 3'd3,
        K_CLEAR     = 3'd4,
        K_REVERSE   = 3'd5,
        K_UPDATE    = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOMATCH = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SEL_HOLD  = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2,
        SEL_NEW   = 2'd3
    } t_cell_sel;

    typedef struct packed {
        t_cell_sel sel;
        logic      cmp_en;
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

>>> rtl/ofru_cell.sv
module ofru_cell #(
    parameter int DATA_WIDTH = ofru_pkg::DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  ofru_pkg::t_cell_ctl   i_ctl,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_new,
    input  logic [DATA_WIDTH-1:0] i_match,
    output logic [DATA_WIDTH-1:0] o_word,
    output logic                  o_hit
);
    import ofru_pkg::*;

    logic [DATA_WIDTH-1:0] r_word;
    logic                  r_hit;

    always_ff @(posedge i_clk) begin
        case (i_ctl.sel)
            SEL_LEFT:  r_word <= i_left;
            SEL_RIGHT: r_word <= i_right;
            SEL_NEW:   r_word <= i_new;
            default:   r_word <= r_word;
        endcase
    end

    // compare is taken when a request is accepted, before the word can change
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_hit <= (r_word == i_match);
        end
    end

    assign o_word = r_word;
    assign o_hit  = r_hit;

endmodule

>>> rtl/overwriting_fifo_with_reverse_update.sv
// result: the request is registered on acceptance and applied in S_EXEC, where the result
//   and the o_valid strobe are registered from the apply state
// requests: no new request is taken while busy (compare in the cell row, then apply state)
// reset: synchronous active low; clears count, direction and pending result,
//   capacity returns to DEPTH; stored words are not reset
// the receiver cannot stall: each result is shown for exactly one cycle on o_valid
module overwriting_fifo_with_reverse_update #(
    parameter int DEPTH      = ofru_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = ofru_pkg::DEF_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ofru_pkg::KIND_W-1:0]    i_kind,
    input  logic [DATA_WIDTH-1:0]          i_data,
    input  logic [DATA_WIDTH-1:0]          i_match_value,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ofru_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                           o_valid,
    output logic [DATA_WIDTH-1:0]          o_value,
    output logic [1:0]                     o_status,
    output logic                           o_dropped_oldest,
    output logic [ofru_pkg::CNT_OUT_W-1:0] o_count,
    output logic                           o_is_empty,
    output logic                           o_is_full
);
    import ofru_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);

    t_state                r_state, n_state;
    logic                  accept;
    logic                  exec_en;

    t_kind                 r_kind;
    logic [DATA_WIDTH-1:0] r_data;

    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_rev, n_rev;
    logic [CNT_W-1:0]      r_cap, n_cap;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    t_status               r_status, n_status;
    logic                  r_drop, n_drop;
    logic                  r_empty, r_full;

    logic [DATA_WIDTH-1:0] words [DEPTH];
    logic [DEPTH-1:0]      hits;
    t_cell_sel             sel [DEPTH];
    t_cell_ctl             ctl [DEPTH];

    logic [IW-1:0]         last_pos, head_pos, tail_pos, rd_pos;
    logic [DATA_WIDTH-1:0] rd_word;
    logic                  nonempty;
    logic                  enq_drop;

    logic [DEPTH-1:0]      live_hits, rev_hits, low_hit, high_rev, pick;

    // ---------------- control ----------------
    assign accept = start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy    = 1'b0;
        exec_en = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy    = 1'b0;
                exec_en = 1'b0;
            end
            S_EXEC: begin
                busy    = 1'b1;
                exec_en = 1'b1;
            end
            default: begin
                busy    = 1'b1;
                exec_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= t_kind'(i_kind);
            r_data <= i_data;
        end
    end

    // ---------------- capacity register ----------------
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_cap = CNT_W'(1);
        end else if (int'(i_cfg_data) > DEPTH) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = CNT_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CNT_W'(DEPTH);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= n_cap;
        end
    end

    // ---------------- cell row ----------------
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_word, right_word;

            if (g == 0) begin : g_first
                assign left_word = '0;
            end else begin : g_mid_l
                assign left_word = words[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign right_word = '0;
            end else begin : g_mid_r
                assign right_word = words[g+1];
            end

            assign ctl[g].sel    = exec_en ? sel[g] : SEL_HOLD;
            assign ctl[g].cmp_en = accept;

            ofru_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl[g]),
                .i_left  (left_word),
                .i_right (right_word),
                .i_new   (r_data),
                .i_match (i_match_value),
                .o_word  (words[g]),
                .o_hit   (hits[g])
            );
        end
    endgenerate

    // ---------------- positions and read ----------------
    assign nonempty = (r_count != '0);
    assign last_pos = IW'(r_count - CNT_W'(1));
    assign head_pos = r_rev ? last_pos : '0;
    assign tail_pos = r_rev ? '0 : last_pos;
    assign rd_pos   = (r_kind == K_PEEK_TAIL) ? tail_pos : head_pos;
    assign rd_word  = words[rd_pos];
    assign enq_drop = (r_count >= r_cap) && nonempty;

    // first live match from the head: lowest cell, or highest when reversed
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            live_hits[i] = hits[i] && (CNT_W'(i) < r_count);
        end
        for (int i = 0; i < DEPTH; i++) begin
            rev_hits[i] = live_hits[DEPTH-1-i];
        end
        low_hit  = live_hits & (~live_hits + DEPTH'(1));
        high_rev = rev_hits & (~rev_hits + DEPTH'(1));
        for (int i = 0; i < DEPTH; i++) begin
            pick[i] = r_rev ? high_rev[DEPTH-1-i] : low_hit[i];
        end
    end

    // ---------------- apply ----------------
    always_comb begin
        n_count  = r_count;
        n_rev    = r_rev;
        n_value  = '0;
        n_status = ST_OK;
        n_drop   = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            sel[i] = SEL_HOLD;
        end
        case (r_kind)
            K_ENQ: begin
                n_drop = enq_drop;
                if (r_rev) begin
                    // dropping the head just trims the far end, then shift in at cell 0
                    for (int i = 0; i < DEPTH; i++) begin
                        sel[i] = (i == 0) ? SEL_NEW : SEL_LEFT;
                    end
                    if (!enq_drop) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end else if (enq_drop) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        sel[i] = (IW'(i) == last_pos) ? SEL_NEW : SEL_RIGHT;
                    end
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CNT_W'(i) == r_count) begin
                            sel[i] = SEL_NEW;
                        end
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            K_DEQ: begin
                if (nonempty) begin
                    n_value = rd_word;
                    n_count = r_count - CNT_W'(1);
                    if (!r_rev) begin
                        for (int i = 0; i < DEPTH; i++) begin
                            sel[i] = SEL_RIGHT;
                        end
                    end
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            K_PEEK_HEAD, K_PEEK_TAIL: begin
                if (nonempty) begin
                    n_value = rd_word;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            K_CLEAR: begin
                n_count = '0;
                n_rev   = 1'b0;
            end
            K_REVERSE: begin
                if (nonempty) begin
                    n_rev = ~r_rev;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            K_UPDATE: begin
                if (|pick) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (pick[i]) begin
                            sel[i] = SEL_NEW;
                        end
                    end
                end else begin
                    n_status = ST_NOMATCH;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rev   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= exec_en;
            if (exec_en) begin
                r_count <= n_count;
                r_rev   <= n_rev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_en) begin
            r_value  <= n_value;
            r_status <= n_status;
            r_drop   <= n_drop;
            r_empty  <= (n_count == '0);
            r_full   <= (n_count == r_cap);
        end
    end

    assign o_valid          = r_valid;
    assign o_value          = r_value;
    assign o_status         = r_status;
    assign o_dropped_oldest = r_drop;
    assign o_count          = CNT_OUT_W'(r_count);
    assign o_is_empty       = r_empty;
    assign o_is_full        = r_full;

    // ---------------- checks ----------------
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("accepted request produced no result");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EXEC))
        else $error("result strobe without an apply cycle");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than the apply cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_single_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_en && r_kind == K_UPDATE) |-> $onehot0(pick))
        else $error("update would write more than one entry");

endmodule

>>> tb/overwriting_fifo_with_reverse_update_tb.sv
module overwriting_fifo_with_reverse_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ofru_pkg::*;

    localparam int            QDEPTH      = DEF_DEPTH;
    localparam int            WATCHDOG    = 500;
    localparam int            CFG_SETTLE  = 4;
    localparam int            PHASES      = 10;
    localparam int            PHASE_ITEMS = 105;
    localparam logic [2:0]    KIND_NOP    = 3'd7;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
        logic        dropped;
        logic [4:0]  count;
        logic        empty;
        logic        full;
    } t_fifo_result;

    class t_fifo_scoreboard;
        logic [31:0]  held[$];
        t_fifo_result want_q[$];
        int unsigned  cap;
        int           errors;
        int           kinds[8];
        int           drops;
        int           update_hits;
        int           empty_hits;
        int           cap_writes;

        function new();
            cap = QDEPTH;
        endfunction

        function void write_capacity(logic [4:0] v);
            cap = (v == 0) ? 1 : ((v > QDEPTH) ? QDEPTH : v);
            cap_writes++;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        // a word that is in the queue now, if any, so updates find matches
        function logic [31:0] any_held();
            if (held.size() == 0)
                return $urandom();
            return held[$urandom_range(0, held.size() - 1)];
        endfunction

        function void note_request(logic [2:0] kind, logic [31:0] data, logic [31:0] match);
            t_fifo_result r;
            r = '{value: '0, status: ST_OK, dropped: 1'b0, count: '0, empty: 1'b0, full: 1'b0};
            kinds[kind]++;
            case (kind)
                K_ENQ: begin
                    // a full queue loses only its head, even above capacity
                    if (held.size() >= cap && held.size() > 0) begin
                        void'(held.pop_front());
                        r.dropped = 1'b1;
                        drops++;
                    end
                    held.push_back(data);
                end
                K_DEQ, K_PEEK_HEAD, K_PEEK_TAIL, K_REVERSE: begin
                    if (held.size() == 0) begin
                        r.status = ST_EMPTY;
                        empty_hits++;
                    end else if (kind == K_DEQ) begin
                        r.value = held.pop_front();
                    end else if (kind == K_PEEK_HEAD) begin
                        r.value = held[0];
                    end else if (kind == K_PEEK_TAIL) begin
                        r.value = held[$];
                    end else begin
                        held.reverse();
                    end
                end
                K_CLEAR: begin
                    held.delete();
                end
                K_UPDATE: begin
                    r.status = ST_NOMATCH;
                    for (int i = 0; i < held.size(); i++) begin
                        if (held[i] == match) begin
                            held[i] = data;
                            r.status = ST_OK;
                            update_hits++;
                            break;
                        end
                    end
                end
                default: begin
                end
            endcase
            r.count = 5'(held.size());
            r.empty = (held.size() == 0);
            r.full  = (held.size() == cap);
            want_q.push_back(r);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
            end
        endfunction

        function void check_result(logic [31:0] v, logic [1:0] st, logic dr, logic [4:0] cnt,
                                   logic emp, logic ful);
            t_fifo_result w;
            if (want_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding, value %h status %h",
                         $time, v, st);
                return;
            end
            w = want_q.pop_front();
            cmp_field("value", w.value, v);
            cmp_field("status", 32'(w.status), 32'(st));
            cmp_field("dropped_oldest", 32'(w.dropped), 32'(dr));
            cmp_field("count", 32'(w.count), 32'(cnt));
            cmp_field("is_empty", 32'(w.empty), 32'(emp));
            cmp_field("is_full", 32'(w.full), 32'(ful));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind;
    logic [31:0]          i_data;
    logic [31:0]          i_match_value;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_valid;
    logic [31:0]          o_value;
    logic [1:0]           o_status;
    logic                 o_dropped_oldest;
    logic [CNT_OUT_W-1:0] o_count;
    logic                 o_is_empty;
    logic                 o_is_full;

    t_fifo_scoreboard sb;
    int               idle_cycles;
    int               gap_max;

    overwriting_fifo_with_reverse_update dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_data           (i_data),
        .i_match_value    (i_match_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_value          (o_value),
        .o_status         (o_status),
        .o_dropped_oldest (o_dropped_oldest),
        .o_count          (o_count),
        .o_is_empty       (o_is_empty),
        .o_is_full        (o_is_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // one process sees every handshake, so prediction order is fixed
    always @(posedge i_clk) begin
        logic moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check_result(o_value, o_status, o_dropped_oldest, o_count,
                                o_is_empty, o_is_full);
                moved = 1'b1;
            end
            if (start && !busy) begin
                sb.note_request(i_kind, i_data, i_match_value);
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_capacity(i_cfg_data);
                moved = 1'b1;
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    initial begin
        do @(posedge i_clk); while (idle_cycles < WATCHDOG);
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
        $display("Verification failed");
        $finish;
    end

    task automatic send_request(input logic [2:0] k, input logic [31:0] d, input logic [31:0] m);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_kind        <= k;
        i_data        <= d;
        i_match_value <= m;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic set_capacity(input logic [4:0] v);
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (CFG_SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(0, 7);   // repeats give duplicate entries
            default: return $urandom();
        endcase
    endfunction

    task automatic random_request(input int enq_pct);
        logic [2:0]  k;
        logic [31:0] m;
        int          r;
        if ($urandom_range(0, 99) < enq_pct) begin
            k = K_ENQ;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 35)      k = K_DEQ;
            else if (r < 50) k = K_PEEK_HEAD;
            else if (r < 62) k = K_PEEK_TAIL;
            else if (r < 72) k = K_REVERSE;
            else if (r < 95) k = K_UPDATE;
            else if (r < 98) k = K_CLEAR;
            else             k = KIND_NOP;
        end
        m = ($urandom_range(0, 99) < 65) ? sb.any_held() : pick_word();
        send_request(k, pick_word(), m);
    endtask

    initial begin
        logic [4:0] cap_pick[7];
        int         enq_pct;
        sb            = new();
        cap_pick      = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd2, 5'd17, 5'd8};
        idle_cycles   = 0;
        gap_max       = 18;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_kind        = K_ENQ;
        i_data        = '0;
        i_match_value = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue first, then a short fill with reverse and update
        send_request(K_DEQ, 32'h0, 32'h0);
        send_request(K_PEEK_HEAD, 32'h0, 32'h0);
        send_request(K_PEEK_TAIL, 32'h0, 32'h0);
        send_request(K_REVERSE, 32'h0, 32'h0);
        send_request(K_UPDATE, 32'h1, 32'h0);
        send_request(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(K_ENQ, 32'h0000_0000, 32'h0);
        send_request(K_ENQ, 32'hFFFF_FFFF, 32'h0);
        send_request(K_ENQ, 32'h1234_5678, 32'h0);
        send_request(K_PEEK_HEAD, 32'h0, 32'h0);
        send_request(K_PEEK_TAIL, 32'h0, 32'h0);
        send_request(K_REVERSE, 32'h0, 32'h0);
        send_request(K_PEEK_HEAD, 32'h0, 32'h0);
        send_request(K_UPDATE, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
        send_request(K_UPDATE, 32'h0BAD_F00D, 32'h7777_7777);
        send_request(K_DEQ, 32'h0, 32'h0);
        send_request(K_ENQ, 32'h8000_0001, 32'h0);
        send_request(KIND_NOP, 32'h0, 32'h0);
        send_request(K_CLEAR, 32'h0, 32'h0);
        // capacity written as zero behaves as one
        set_capacity(5'd0);
        send_request(K_ENQ, 32'h1111_1111, 32'h0);
        send_request(K_ENQ, 32'h2222_2222, 32'h0);
        // above the depth clamps to the depth, then shrink below the count
        set_capacity(5'd31);
        send_request(K_ENQ, 32'h3333_3333, 32'h0);
        send_request(K_ENQ, 32'h4444_4444, 32'h0);
        set_capacity(5'd2);
        send_request(K_ENQ, 32'h5555_5555, 32'h0);
        send_request(K_DEQ, 32'h0, 32'h0);

        for (int p = 0; p < PHASES; p++) begin
            set_capacity(p < 7 ? cap_pick[p] : 5'($urandom_range(0, 31)));
            enq_pct = $urandom_range(30, 70);
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request(enq_pct);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("ran %0d enqueues (%0d dropped the oldest), %0d dequeues, %0d peeks, %0d clears",
                 sb.kinds[K_ENQ], sb.drops, sb.kinds[K_DEQ],
                 sb.kinds[K_PEEK_HEAD] + sb.kinds[K_PEEK_TAIL], sb.kinds[K_CLEAR]);
        $display("%0d reverses, %0d updates (%0d hit), %0d empty statuses, %0d capacity writes",
                 sb.kinds[K_REVERSE], sb.kinds[K_UPDATE], sb.update_hits, sb.empty_hits,
                 sb.cap_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
